// ----- rtl/wti_pkg.sv -----
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Shared sizes, codes and sequencer states of the interpolating oscillator.
// ----------------------------------------------------------------------------
package wti_pkg;

	// Sizes of the phase accumulator, the table and the samples.
	localparam int TABLE_ADDR_BITS = 12;
	localparam int TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
	localparam int PHASE_BITS      = 24;
	localparam int SAMPLE_BITS     = 16;
	localparam int LO_BITS         = PHASE_BITS - TABLE_ADDR_BITS;
	localparam int AMP_BITS        = 16;
	localparam int AMP_FRAC        = 15;

	// Operand width of the shared multiplier: a sample difference, a
	// zero-extended fraction or a sign-extended amplitude must all fit.
	localparam int MUL_W_A = SAMPLE_BITS + 1;
	localparam int MUL_W_B = (LO_BITS + 1 > AMP_BITS) ? LO_BITS + 1 : AMP_BITS;
	localparam int MUL_W   = (MUL_W_A > MUL_W_B) ? MUL_W_A : MUL_W_B;
	localparam int PROD_W  = 2 * MUL_W;

	// Saturation limits of the output sample.
	localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [PROD_W-1:0] SAT_MIN = ~SAT_MAX;

	// Item modes.
	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_TICK    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// Configuration register indexes and port width.
	localparam int         PADDR_BITS = 4;
	localparam logic [1:0] REG_INC    = 2'd0;
	localparam logic [1:0] REG_AMP    = 2'd1;
	localparam logic [1:0] REG_START  = 2'd2;
	localparam logic signed [AMP_BITS-1:0] AMP_RESET = 16'sd6554;

	// Sequencer states of a tick.
	typedef enum logic [2:0] {
		S_IDLE,
		S_RDA,
		S_RDB,
		S_MUL1,
		S_MUL2,
		S_SAT
	} state_t;

endpackage

// ----- rtl/wti_in_if.sv -----
// ----------------------------------------------------------------------------
// Oscillator request channel
// Valid/ready channel that carries one request: mode, table index and value.
// ----------------------------------------------------------------------------
interface wti_in_if import wti_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [1:0]                    mode;
	logic [TABLE_ADDR_BITS-1:0]    table_index;
	logic signed [SAMPLE_BITS-1:0] table_value;

	modport source (output valid, output mode, output table_index, output table_value,
		input ready);
	modport sink (input valid, input mode, input table_index, input table_value,
		output ready);
endinterface

// ----- rtl/wti_out_if.sv -----
// ----------------------------------------------------------------------------
// Oscillator sample channel
// Valid/ready channel that carries one output sample.
// ----------------------------------------------------------------------------
interface wti_out_if import wti_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ----- rtl/wti_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module wti_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/wavetable_oscillator_interp.sv -----
// ----------------------------------------------------------------------------
// Wavetable oscillator with linear interpolation
// Write and restart requests leave the sequencer idle. A tick steps through
// two RAM reads, two shared multiplies and saturation, which waits for a free
// output slot; the sequencer then returns to idle and takes the next request.
// The result register lets that request in while a sample waits.
// Reset clears phase, configuration, state and output valid at once; the table and datapath registers are not cleared.
// ----------------------------------------------------------------------------
module wavetable_oscillator_interp import wti_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	wti_in_if.sink                item,
	wti_out_if.source             result
);

	state_t state_q, state_d;

	logic [PHASE_BITS-1:0]         phase_q;
	logic [PHASE_BITS-1:0]         inc_q;
	logic [PHASE_BITS-1:0]         start_q;
	logic signed [AMP_BITS-1:0]    amp_q;
	logic [TABLE_ADDR_BITS-1:0]    ia_q;
	logic [LO_BITS-1:0]            frac_q;
	logic signed [SAMPLE_BITS-1:0] a_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          out_valid_q;

	logic                          accept;
	logic                          cfg_we;
	logic [TABLE_ADDR_BITS-1:0]    raddr;
	logic signed [SAMPLE_BITS-1:0] rdata;
	logic                          sel_interp;
	logic                          load_a;
	logic                          load_prod;
	logic                          load_out;
	logic signed [MUL_W-1:0]       op_x;
	logic signed [MUL_W-1:0]       op_y;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      interp_full;
	logic signed [PROD_W-1:0]      scaled;
	logic signed [SAMPLE_BITS-1:0] sat;

	assign accept = item.valid && item.ready;
	assign cfg_we = psel && penable && pwrite;
	assign pready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= '0;
			amp_q   <= AMP_RESET;
			start_q <= '0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_INC:   inc_q   <= pwdata[PHASE_BITS-1:0];
				REG_AMP:   amp_q   <= pwdata[AMP_BITS-1:0];
				REG_START: start_q <= pwdata[PHASE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			REG_INC:   prdata = 32'(inc_q);
			REG_AMP:   prdata = 32'(unsigned'(amp_q));
			REG_START: prdata = 32'(start_q);
			default:   prdata = '0;
		endcase
	end

	// Wave table storage.
	wti_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (accept && item.mode == MODE_WRITE),
		.waddr (item.table_index),
		.wdata (item.table_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept && item.mode == MODE_TICK) state_d = S_RDA;
			S_RDA:  state_d = S_RDB;
			S_RDB:  state_d = S_MUL1;
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_SAT;
			S_SAT:  if (load_out) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		raddr      = ia_q;
		sel_interp = 1'b0;
		load_a     = 1'b0;
		load_prod  = 1'b0;
		load_out   = 1'b0;
		item.ready = 1'b0;
		unique case (state_q)
			S_IDLE: item.ready = 1'b1;
			S_RDA:  raddr = ia_q;
			S_RDB: begin
				raddr  = ia_q + 1'b1;
				load_a = 1'b1;
			end
			S_MUL1: load_prod = 1'b1;
			S_MUL2: begin
				sel_interp = 1'b1;
				load_prod  = 1'b1;
			end
			S_SAT:  load_out = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	// Phase accumulator; a tick latches its index and fraction and steps on, a restart loads the start phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			if (item.mode == MODE_TICK) begin
				phase_q <= phase_q + inc_q;
			end else if (item.mode == MODE_RESTART) begin
				phase_q <= start_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.mode == MODE_TICK) begin
			ia_q   <= phase_q[PHASE_BITS-1:LO_BITS];
			frac_q <= phase_q[LO_BITS-1:0];
		end
	end

	// Interpolated value from the first product: a + floor((b - a) * frac).
	assign interp_full = PROD_W'(a_q) + (prod_q >>> LO_BITS);

	// Shared multiplier: difference by fraction, then interpolation by gain.
	always_comb begin
		if (sel_interp) begin
			op_x = interp_full[MUL_W-1:0];
			op_y = MUL_W'(amp_q);
		end else begin
			op_x = MUL_W'(rdata) - MUL_W'(a_q);
			op_y = MUL_W'(frac_q);
		end
	end

	assign prod = PROD_W'(op_x) * PROD_W'(op_y);

	always_ff @(posedge clk) begin
		if (load_a) begin
			a_q <= rdata;
		end
		if (load_prod) begin
			prod_q <= prod;
		end
	end

	// Gain scaling and saturation to the sample range.
	assign scaled = prod_q >>> AMP_FRAC;

	always_comb begin
		priority if (scaled > SAT_MAX) begin
			sat = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (scaled < SAT_MIN) begin
			sat = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			sat = scaled[SAMPLE_BITS-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sample_q <= sat;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.sample = sample_q;

`ifndef SYNTHESIS
	// A tick request keeps the block busy in the following cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.mode == MODE_TICK |=> !item.ready)
		else $error("request taken right after a tick");

	// A new sample appears only from the saturation step.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == S_SAT))
		else $error("sample valid without a saturation step");

	// With a free output slot the saturation step loads the sample and the sequencer is idle in the next cycle.
	a_sat_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SAT && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
		else $error("saturated sample not loaded");
`endif

endmodule
